### hw/rtl/dva_pkg.sv
package dva_pkg;

  // Field and datapath widths.
  localparam int COORD_BITS    = 24;
  localparam int DIFF_BITS     = COORD_BITS + 1;
  localparam int SQ_BITS       = 2 * COORD_BITS + 1;
  localparam int SUM_BITS      = SQ_BITS + 1;
  localparam int DIST_BITS     = 25;
  localparam int ROOT_STAGES   = SUM_BITS / 2;
  localparam int SREM_BITS     = DIST_BITS + 2;
  localparam int GAIN_BITS     = 17;
  localparam int NEAR_BITS     = 22;
  localparam int SPAN_BITS     = NEAR_BITS + 1;
  localparam int PROD_BITS     = GAIN_BITS + SPAN_BITS;
  localparam int DIV_STAGES    = GAIN_BITS;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = NEAR_BITS;

  localparam logic [GAIN_BITS-1:0] VOLUME_MAX   = GAIN_BITS'(65536);
  localparam logic [SPAN_BITS-1:0] NEAR_FAR_GAP = SPAN_BITS'(3);

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ENABLE      = 2'd0,
    REG_BASE_VOLUME = 2'd1,
    REG_NEAR        = 2'd2,
    REG_FAR         = 2'd3
  } cfg_reg_e;

  // How the gain of one word is formed.
  typedef enum logic [1:0] {
    GAIN_ZERO,
    GAIN_FULL,
    GAIN_DIV
  } gain_mode_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] source_x;
    logic signed [COORD_BITS-1:0] source_y;
    logic signed [COORD_BITS-1:0] source_z;
    logic signed [COORD_BITS-1:0] listener_x;
    logic signed [COORD_BITS-1:0] listener_y;
    logic signed [COORD_BITS-1:0] listener_z;
  } in_word_t;

  typedef struct packed {
    logic [DIST_BITS-1:0] distance;
    logic [GAIN_BITS-1:0] gain;
  } out_word_t;

  typedef struct packed {
    logic                 enable;
    logic [GAIN_BITS-1:0] volume;
    logic [NEAR_BITS-1:0] near_distance;
    logic [NEAR_BITS-1:0] far_distance;
  } cfg_t;

endpackage

### hw/rtl/dva_dist.sv
module dva_dist
  import dva_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  in_word_t            word_i,
  output logic                valid_o,
  output logic [SUM_BITS-1:0] sum_o
);

  logic signed [DIFF_BITS-1:0] dx, dy, dz;
  logic [DIFF_BITS-1:0] ax_d, ay_d, az_d, ax_q, ay_q, az_q;
  logic [SQ_BITS-1:0]   sx_q, sy_q, sz_q;
  logic [2*DIFF_BITS-1:0] px, py, pz;
  logic [SUM_BITS-1:0]  sum_q;
  logic [2:0]           v_q;

  // Absolute coordinate differences.
  always_comb begin
    dx = DIFF_BITS'(word_i.listener_x) - DIFF_BITS'(word_i.source_x);
    dy = DIFF_BITS'(word_i.listener_y) - DIFF_BITS'(word_i.source_y);
    dz = DIFF_BITS'(word_i.listener_z) - DIFF_BITS'(word_i.source_z);
    ax_d = dx[DIFF_BITS-1] ? DIFF_BITS'(-dx) : DIFF_BITS'(dx);
    ay_d = dy[DIFF_BITS-1] ? DIFF_BITS'(-dy) : DIFF_BITS'(dy);
    az_d = dz[DIFF_BITS-1] ? DIFF_BITS'(-dz) : DIFF_BITS'(dz);
  end

  // Squares of the differences.
  always_comb begin
    px = ax_q * ax_q;
    py = ay_q * ay_q;
    pz = az_q * az_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q  <= ax_d;
      ay_q  <= ay_d;
      az_q  <= az_d;
      sx_q  <= px[SQ_BITS-1:0];
      sy_q  <= py[SQ_BITS-1:0];
      sz_q  <= pz[SQ_BITS-1:0];
      sum_q <= SUM_BITS'(sx_q) + SUM_BITS'(sy_q) + SUM_BITS'(sz_q);
    end
  end

  assign valid_o = v_q[2];
  assign sum_o   = sum_q;

endmodule

### hw/rtl/dva_sqrt.sv
module dva_sqrt
  import dva_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [SUM_BITS-1:0]  rad_i,
  output logic                 valid_o,
  output logic [DIST_BITS-1:0] root_o
);

  logic                 v_q    [ROOT_STAGES];
  logic [SUM_BITS-1:0]  rad_q  [ROOT_STAGES];
  logic [SREM_BITS-1:0] rem_q  [ROOT_STAGES];
  logic [DIST_BITS-1:0] root_q [ROOT_STAGES];

  // One result bit per stage, restoring method.
  for (genvar k = 0; k < ROOT_STAGES; k++) begin : g_stage
    logic                 v_in;
    logic [SUM_BITS-1:0]  rad_in;
    logic [SREM_BITS-1:0] rem_in;
    logic [DIST_BITS-1:0] root_in;
    logic [SREM_BITS+1:0] rem_sh, trial;
    logic [SREM_BITS-1:0] rem_d;
    logic [DIST_BITS-1:0] root_d;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    always_comb begin
      rem_sh = {rem_in, rad_in[SUM_BITS-1 -: 2]};
      trial  = {1'b0, root_in, 2'b01};
      if (rem_sh >= trial) begin
        rem_d  = SREM_BITS'(rem_sh - trial);
        root_d = {root_in[DIST_BITS-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh[SREM_BITS-1:0];
        root_d = {root_in[DIST_BITS-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= {rad_in[SUM_BITS-3:0], 2'b00};
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
      end
    end
  end

  assign valid_o = v_q[ROOT_STAGES-1];
  assign root_o  = root_q[ROOT_STAGES-1];

endmodule

### hw/rtl/dva_gain.sv
module dva_gain
  import dva_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  cfg_t                 cfg_i,
  input  logic                 valid_i,
  input  logic [DIST_BITS-1:0] dist_i,
  output logic                 valid_o,
  output out_word_t            word_o
);

  logic [SPAN_BITS-1:0] near_gap, far_eff;
  gain_mode_e           mode_d, mode_a_q, mode_b_q;
  logic [SPAN_BITS-1:0] diff_d, diff_a_q, den_a_q, den_b_q;
  logic [GAIN_BITS-1:0] vol_a_q, vol_b_q;
  logic [DIST_BITS-1:0] dist_a_q, dist_b_q;
  logic [PROD_BITS-1:0] prod_b_q;
  logic                 v_a_q, v_b_q;

  // Classify the distance against the near and effective far bounds.
  always_comb begin
    near_gap = SPAN_BITS'(cfg_i.near_distance) + NEAR_FAR_GAP;
    far_eff  = (SPAN_BITS'(cfg_i.far_distance) < near_gap) ? near_gap
                                                           : SPAN_BITS'(cfg_i.far_distance);
    diff_d   = far_eff - dist_i[SPAN_BITS-1:0];
    if (!cfg_i.enable || cfg_i.volume == '0) begin
      mode_d = GAIN_ZERO;
    end else if (dist_i <= DIST_BITS'(cfg_i.near_distance)) begin
      mode_d = GAIN_FULL;
    end else if (dist_i >= DIST_BITS'(far_eff)) begin
      mode_d = GAIN_ZERO;
    end else begin
      mode_d = GAIN_DIV;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
      v_b_q <= 1'b0;
    end else if (en_i) begin
      v_a_q <= valid_i;
      v_b_q <= v_a_q;
    end
  end

  // Classification stage, then the numerator product.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode_a_q <= mode_d;
      diff_a_q <= diff_d;
      den_a_q  <= far_eff - SPAN_BITS'(cfg_i.near_distance);
      vol_a_q  <= cfg_i.volume;
      dist_a_q <= dist_i;
      mode_b_q <= mode_a_q;
      prod_b_q <= vol_a_q * diff_a_q;
      den_b_q  <= den_a_q;
      vol_b_q  <= vol_a_q;
      dist_b_q <= dist_a_q;
    end
  end

  logic                 dv_q    [DIV_STAGES];
  gain_mode_e           dmode_q [DIV_STAGES];
  logic [SPAN_BITS-1:0] dden_q  [DIV_STAGES];
  logic [SPAN_BITS-1:0] drem_q  [DIV_STAGES];
  logic [GAIN_BITS-1:0] dlo_q   [DIV_STAGES];
  logic [GAIN_BITS-1:0] dquo_q  [DIV_STAGES];
  logic [GAIN_BITS-1:0] dvol_q  [DIV_STAGES];
  logic [DIST_BITS-1:0] ddist_q [DIV_STAGES];

  // Restoring division, one quotient bit per stage. The quotient is below
  // the volume, so the upper product bits start out below the divisor.
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    logic                 v_in;
    gain_mode_e           mode_in;
    logic [SPAN_BITS-1:0] den_in, rem_in;
    logic [GAIN_BITS-1:0] lo_in, quo_in, vol_in;
    logic [DIST_BITS-1:0] dist_in;
    logic [SPAN_BITS:0]   rem_sh;
    logic [SPAN_BITS-1:0] rem_d;
    logic                 qbit;

    if (k == 0) begin : g_first
      assign v_in    = v_b_q;
      assign mode_in = mode_b_q;
      assign den_in  = den_b_q;
      assign rem_in  = prod_b_q[PROD_BITS-1:GAIN_BITS];
      assign lo_in   = prod_b_q[GAIN_BITS-1:0];
      assign quo_in  = '0;
      assign vol_in  = vol_b_q;
      assign dist_in = dist_b_q;
    end else begin : g_next
      assign v_in    = dv_q[k-1];
      assign mode_in = dmode_q[k-1];
      assign den_in  = dden_q[k-1];
      assign rem_in  = drem_q[k-1];
      assign lo_in   = dlo_q[k-1];
      assign quo_in  = dquo_q[k-1];
      assign vol_in  = dvol_q[k-1];
      assign dist_in = ddist_q[k-1];
    end

    always_comb begin
      rem_sh = {rem_in, lo_in[GAIN_BITS-1]};
      qbit   = (rem_sh >= {1'b0, den_in});
      rem_d  = qbit ? SPAN_BITS'(rem_sh - {1'b0, den_in}) : rem_sh[SPAN_BITS-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= 1'b0;
      end else if (en_i) begin
        dv_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dmode_q[k] <= mode_in;
        dden_q[k]  <= den_in;
        drem_q[k]  <= rem_d;
        dlo_q[k]   <= {lo_in[GAIN_BITS-2:0], 1'b0};
        dquo_q[k]  <= {quo_in[GAIN_BITS-2:0], qbit};
        dvol_q[k]  <= vol_in;
        ddist_q[k] <= dist_in;
      end
    end
  end

  // Final gain selection.
  always_comb begin
    word_o.distance = ddist_q[DIV_STAGES-1];
    case (dmode_q[DIV_STAGES-1])
      GAIN_FULL: word_o.gain = dvol_q[DIV_STAGES-1];
      GAIN_DIV:  word_o.gain = dquo_q[DIV_STAGES-1];
      default:   word_o.gain = '0;
    endcase
  end

  assign valid_o = dv_q[DIV_STAGES-1];

endmodule

### hw/rtl/distance_volume_attenuation_top.sv
// Throughput: one word per cycle while the output is not stalled; the 25-stage
// square root and the 17-stage divider are fully pipelined and a stall at the
// output holds every stage. Reset (rst_ni low, asynchronous) empties the pipeline
// and loads the registers with enable 1, volume 1.0, near 1.0 and far 100.0.
module distance_volume_attenuation_top
  import dva_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  in_word_t                 in_word_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output out_word_t                out_word_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  logic                 en;
  logic                 enable_q;
  logic [GAIN_BITS-1:0] volume_q;
  logic [NEAR_BITS-1:0] near_q, far_q;
  cfg_t                 cfg;
  logic                 sum_valid, root_valid, gain_valid;
  logic [SUM_BITS-1:0]  sum;
  logic [DIST_BITS-1:0] root;
  out_word_t            gain_word, out_q;
  logic                 out_valid_q;

  // The whole pipeline advances unless a held result is stalled.
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
      volume_q <= GAIN_BITS'(16384);
      near_q   <= NEAR_BITS'(256);
      far_q    <= NEAR_BITS'(25600);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_ENABLE:      enable_q <= cfg_data_i[0];
        REG_BASE_VOLUME: volume_q <= cfg_data_i[GAIN_BITS-1:0];
        REG_NEAR:        near_q   <= cfg_data_i;
        REG_FAR:         far_q    <= cfg_data_i;
        default:         ;
      endcase
    end
  end

  // Volume above 4.0 saturates.
  always_comb begin
    cfg.enable        = enable_q;
    cfg.volume        = (volume_q > VOLUME_MAX) ? VOLUME_MAX : volume_q;
    cfg.near_distance = near_q;
    cfg.far_distance  = far_q;
  end

  dva_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .word_i  (in_word_i),
    .valid_o (sum_valid),
    .sum_o   (sum)
  );

  dva_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sum_valid),
    .rad_i   (sum),
    .valid_o (root_valid),
    .root_o  (root)
  );

  dva_gain u_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg),
    .valid_i (root_valid),
    .dist_i  (root),
    .valid_o (gain_valid),
    .word_o  (gain_word)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= gain_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= gain_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef SYNTHESIS
  a_gain_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.gain <= VOLUME_MAX)
    else $error("gain above full scale");

  a_disabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !enable_q |-> out_word_o.gain == '0)
    else $error("gain nonzero while disabled");

  a_near_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && enable_q && out_word_o.distance <= DIST_BITS'(near_q)
      |-> out_word_o.gain == cfg.volume)
    else $error("gain not full inside near distance");
`endif

endmodule

### test/dva_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the configuration port of the attenuation block,
// predicts every result word and compares it with what the block delivers.
module dva_checker
  import dva_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  in_word_t                 in_word_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  out_word_t                out_word_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  output int                       fail_count_o,
  output int                       pending_o
);

  // Shadow copy of the block's registers.
  logic                 sh_enable;
  logic [GAIN_BITS-1:0] sh_volume;
  logic [NEAR_BITS-1:0] sh_near;
  logic [NEAR_BITS-1:0] sh_far;

  out_word_t attn_expected_q[$];
  int        fails;

  assign fail_count_o = fails;
  assign pending_o    = attn_expected_q.size();

  function automatic longint unsigned isqrt_floor(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n   = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned sq_diff(logic signed [COORD_BITS-1:0] a,
                                              logic signed [COORD_BITS-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d < 0) d = -d;
    return longint'(d) * longint'(d);
  endfunction

  // Computes the distance and gain that one source/listener word should give.
  function automatic out_word_t attenuate(in_word_t w);
    out_word_t       r;
    longint unsigned sum, dist_v, vol, nr, fr, g;
    sum = sq_diff(w.listener_x, w.source_x) + sq_diff(w.listener_y, w.source_y)
        + sq_diff(w.listener_z, w.source_z);
    dist_v = isqrt_floor(sum);
    vol  = (sh_volume > VOLUME_MAX) ? VOLUME_MAX : sh_volume;
    nr   = sh_near;
    fr   = sh_far;
    if (fr < nr + NEAR_FAR_GAP) fr = nr + NEAR_FAR_GAP;
    if (!sh_enable || vol == 0) g = 0;
    else if (dist_v <= nr)      g = vol;
    else if (dist_v >= fr)      g = 0;
    else                        g = (vol * (fr - dist_v)) / (fr - nr);
    r.distance = DIST_BITS'(dist_v);
    r.gain     = GAIN_BITS'(g);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got,
                                 longint unsigned want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
    fails++;
  endtask

  // Registers, predictions and comparisons, all sampled at the clock edge.
  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t exp_w;
    if (!rst_ni) begin
      sh_enable <= 1'b1;
      sh_volume <= GAIN_BITS'(16384);
      sh_near   <= NEAR_BITS'(256);
      sh_far    <= NEAR_BITS'(25600);
      attn_expected_q.delete();
      fails = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_ENABLE:      sh_enable <= cfg_data_i[0];
          REG_BASE_VOLUME: sh_volume <= cfg_data_i[GAIN_BITS-1:0];
          REG_NEAR:        sh_near   <= cfg_data_i;
          REG_FAR:         sh_far    <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) attn_expected_q.push_back(attenuate(in_word_i));
      if (out_valid_i && !out_stall_i) begin
        if (attn_expected_q.size() == 0) begin
          report_mismatch("unexpected word, distance", out_word_i.distance, 0);
        end else begin
          exp_w = attn_expected_q.pop_front();
          if (out_word_i.distance !== exp_w.distance)
            report_mismatch("distance", out_word_i.distance, exp_w.distance);
          if (out_word_i.gain !== exp_w.gain)
            report_mismatch("gain", out_word_i.gain, exp_w.gain);
        end
      end
    end
  end

endmodule

### test/distance_volume_attenuation_top_tb.sv
`timescale 1ns / 1ps

module distance_volume_attenuation_top_tb;
  import dva_pkg::*;

  localparam int IN_WORD_BITS = $bits(in_word_t);

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  in_word_t                 in_word_i   = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  out_word_t                out_word_o;
  logic                     cfg_we_i    = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i  = '0;

  int  fail_count;
  int  pending;
  int  cycles = 0;
  bit  quiet  = 1'b0;
  bit  hold_req = 1'b0;

  distance_volume_attenuation_top dut (.*);

  dva_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_word_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_word_i(out_word_o),
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("distance_volume_attenuation_top regression: fail");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off on request, none when quiet.
  initial begin
    int n;
    forever begin
      if (quiet) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        n = $urandom_range(1, 14);
        out_stall_i <= ($urandom_range(0, 3) == 0);
        repeat (n) @(posedge clk_i);
      end
    end
  end

  // Offers one word, waits for the edge where it is taken, then sometimes idles the input.
  task automatic send_word(in_word_t w);
    int n;
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 14);
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_BITS-1:0] val);
    in_valid_i  <= 1'b0;
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // Word whose listener sits at the given offset from a random source.
  function automatic in_word_t offset_word(int ox, int oy, int oz);
    in_word_t w;
    w.source_x   = COORD_BITS'($urandom);
    w.source_y   = COORD_BITS'($urandom);
    w.source_z   = COORD_BITS'($urandom);
    w.listener_x = w.source_x + COORD_BITS'(ox);
    w.listener_y = w.source_y + COORD_BITS'(oy);
    w.listener_z = w.source_z + COORD_BITS'(oz);
    return w;
  endfunction

  task automatic random_words(int count, int span);
    in_word_t w;
    repeat (count) begin
      case ($urandom_range(0, 3))
        0: w = in_word_t'(IN_WORD_BITS'({$urandom, $urandom, $urandom, $urandom,
                                         $urandom}));
        1: w = offset_word($urandom_range(0, 2 * span) - span, 0, 0);
        default: w = offset_word($urandom_range(0, 2 * span) - span,
                                 $urandom_range(0, 2 * span) - span,
                                 $urandom_range(0, 2 * span) - span);
      endcase
      send_word(w);
    end
  endtask

  localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  initial begin
    in_word_t w;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words at the reset settings: near 256, far 25600.
    send_word('0);
    send_word(in_word_t'({CMAX, CMAX, CMAX, CMIN, CMIN, CMIN}));
    send_word(in_word_t'({CMIN, CMIN, CMIN, CMAX, CMAX, CMAX}));
    send_word(in_word_t'({CMAX, CMIN, CMAX, CMIN, CMAX, CMIN}));
    send_word(offset_word(256, 0, 0));
    send_word(offset_word(0, 257, 0));
    send_word(offset_word(0, 0, -25599));
    send_word(offset_word(25600, 0, 0));
    send_word(offset_word(-255, 0, 0));
    send_word(offset_word(3000, 4000, 0));
    w = offset_word(0, 0, 0);
    send_word(w);
    random_words(150, 30000);
    drain();

    // Disabled block, then enabled again with zero volume.
    write_reg(REG_ENABLE, '0);
    random_words(100, 30000);
    drain();
    write_reg(REG_ENABLE, 22'd1);
    write_reg(REG_BASE_VOLUME, 22'd0);
    random_words(80, 30000);
    drain();

    // Full volume with a long output hold-off so the pipeline backs up.
    write_reg(REG_BASE_VOLUME, 22'd65536);
    write_reg(REG_NEAR, 22'd0);
    write_reg(REG_FAR, 22'd3);
    hold_req = 1'b1;
    send_word(offset_word(1, 0, 0));
    send_word(offset_word(2, 0, 0));
    send_word(offset_word(3, 0, 0));
    random_words(150, 8);
    drain();

    // Volume above 4.0 saturates; far below near uses near plus the gap.
    write_reg(REG_BASE_VOLUME, 22'h1ffff);
    write_reg(REG_NEAR, 22'd1000);
    write_reg(REG_FAR, 22'd0);
    send_word(offset_word(1002, 0, 0));
    send_word(offset_word(1003, 0, 0));
    random_words(150, 1200);
    drain();

    // Largest near and far.
    write_reg(REG_BASE_VOLUME, 22'd12345);
    write_reg(REG_NEAR, 22'h3fffff);
    write_reg(REG_FAR, 22'h3fffff);
    random_words(120, 4300000);
    drain();
    write_reg(REG_NEAR, 22'd0);
    random_words(120, 4300000);
    drain();

    // Random settings, finishing with no idling on either side.
    write_reg(REG_BASE_VOLUME, 22'($urandom_range(1, 65536)));
    write_reg(REG_NEAR, 22'($urandom_range(0, 20000)));
    write_reg(REG_FAR, 22'($urandom_range(3, 60000)));
    random_words(100, 40000);
    drain();
    quiet = 1'b1;
    random_words(120, 40000);
    drain();

    if (fail_count == 0) begin
      $display("distance_volume_attenuation_top regression: pass");
    end else begin
      $display("distance_volume_attenuation_top regression: fail");
    end
    $finish;
  end

endmodule
